// ===== sv/multilevel_process_priority_queue_unit_assert.svh =====
// Assertion macros for the multilevel process priority queue.
// Included by the top level; depends on nothing else.
`ifndef MULTILEVEL_PROCESS_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MULTILEVEL_PROCESS_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define MLPQ_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define MLPQ_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mlpq_pkg.sv =====
// Shared constants, codes and types of the multilevel process priority queue.
// No dependencies.
`default_nettype none

package mlpq_pkg;

  localparam int NUM_LEVELS = 8;
  localparam int CAPACITY   = 64;
  localparam int PID_BITS   = 8;

  localparam int PID_COUNT = 1 << PID_BITS;
  localparam int LVL_W     = $clog2(NUM_LEVELS);
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // fixed widths of the channel fields
  localparam int FUNC_W = 2;
  localparam int PRIO_W = 3;
  localparam int XPID_W = 8;
  localparam int STAT_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXEC   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_DUP      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // read request, issued on the cycle a word is accepted
  typedef struct packed {
    logic              en;
    logic [PID_BITS-1:0] pl_addr;
    logic [SLOT_W-1:0]   fs_addr;
    logic [SLOT_W-1:0]   slot_addr;
  } store_rd_t;

  typedef struct packed {
    logic [LVL_W-1:0]    pl;
    logic [SLOT_W-1:0]   fs;
    logic [PID_BITS-1:0] sp;
    logic [SLOT_W-1:0]   sn;
  } store_q_t;

  typedef struct packed {
    logic                pl_we;
    logic [PID_BITS-1:0] pl_addr;
    logic [LVL_W-1:0]    pl_data;
    logic                sp_we;
    logic [SLOT_W-1:0]   sp_addr;
    logic [PID_BITS-1:0] sp_data;
    logic                sn_we;
    logic [SLOT_W-1:0]   sn_addr;
    logic [SLOT_W-1:0]   sn_data;
    logic                fs_we;
    logic [SLOT_W-1:0]   fs_addr;
    logic [SLOT_W-1:0]   fs_data;
  } store_wr_t;

endpackage

`default_nettype wire

// ===== sv/mlpq_req_if.sv =====
// Request channel of the multilevel process priority queue.
// Depends on mlpq_pkg.
`default_nettype none

interface mlpq_req_if import mlpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PRIO_W-1:0] priority_req;
  logic [XPID_W-1:0] process_id;

  modport source(output valid, func, priority_req, process_id, input ready);
  modport sink(input valid, func, priority_req, process_id, output ready);
endinterface

`default_nettype wire

// ===== sv/mlpq_rsp_if.sv =====
// Response channel of the multilevel process priority queue.
// Depends on mlpq_pkg.
`default_nettype none

interface mlpq_rsp_if import mlpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PRIO_W-1:0] result_priority;
  logic [XPID_W-1:0] result_pid;

  modport source(output valid, status, result_priority, result_pid, input ready);
  modport sink(input valid, status, result_priority, result_pid, output ready);
endinterface

`default_nettype wire

// ===== sv/mlpq_store.sv =====
// Synchronous memories of the queue: per-pid level, slot pid/next links and
// the free-slot stack. Depends on mlpq_pkg.
`default_nettype none

module mlpq_store import mlpq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  store_rd_t rd,
  input  store_wr_t wr,
  output store_q_t  q
);

  logic [LVL_W-1:0]    pl_mem [PID_COUNT];
  logic [PID_BITS-1:0] sp_mem [CAPACITY];
  logic [SLOT_W-1:0]   sn_mem [CAPACITY];
  logic [SLOT_W-1:0]   fs_mem [CAPACITY];

  logic [LVL_W-1:0]    pl_q;
  logic [PID_BITS-1:0] sp_q;
  logic [SLOT_W-1:0]   sn_q;

  // free stack entry i reads as i until first written
  logic [CAPACITY-1:0] fs_written;
  logic                fs_hit;
  logic [SLOT_W-1:0]   fs_raw;
  logic [SLOT_W-1:0]   fs_addr_q;

  always_ff @(posedge clk) begin
    if (wr.pl_we) pl_mem[wr.pl_addr] <= wr.pl_data;
    if (wr.sp_we) sp_mem[wr.sp_addr] <= wr.sp_data;
    if (wr.sn_we) sn_mem[wr.sn_addr] <= wr.sn_data;
    if (wr.fs_we) fs_mem[wr.fs_addr] <= wr.fs_data;
    if (rd.en) begin
      pl_q      <= pl_mem[rd.pl_addr];
      sp_q      <= sp_mem[rd.slot_addr];
      sn_q      <= sn_mem[rd.slot_addr];
      fs_raw    <= fs_mem[rd.fs_addr];
      fs_addr_q <= rd.fs_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fs_written <= '0;
      fs_hit     <= 1'b0;
    end else begin
      if (wr.fs_we) fs_written[wr.fs_addr] <= 1'b1;
      if (rd.en) fs_hit <= fs_written[rd.fs_addr];
    end
  end

  always_comb begin
    q.pl = pl_q;
    q.fs = fs_hit ? fs_raw : fs_addr_q;
    q.sp = sp_q;
    q.sn = sn_q;
  end

endmodule

`default_nettype wire

// ===== sv/multilevel_process_priority_queue_unit.sv =====
// Multilevel process priority queue: one linked FIFO per level in slot memory.
// Result word: registered in the execute state after the request is accepted.
// One request at a time: accept/read in idle, then modify/write back of the
// slot and pid memories in execute, held while the result word is not taken.
// Reset: synchronous; empties every level, no clearing pass, ready at once.
`default_nettype none
`include "multilevel_process_priority_queue_unit_assert.svh"

module multilevel_process_priority_queue_unit import mlpq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mlpq_req_if.sink    req,
  mlpq_rsp_if.source  rsp
);

  state_t state, state_next;

  logic [PID_COUNT-1:0]  pend_flags;
  logic [SLOT_W-1:0]     level_head [NUM_LEVELS];
  logic [SLOT_W-1:0]     level_tail [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] level_nonempty;
  logic [CNT_W-1:0]      used_count;

  logic [FUNC_W-1:0]   func_r;
  logic [LVL_W-1:0]    lvl_r;
  logic [PID_BITS-1:0] pid_r;
  logic [LVL_W-1:0]    first_r;
  logic                pend_r;

  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [PRIO_W-1:0]   out_prio;
  logic [XPID_W-1:0]   out_pid;

  logic req_acc, exec_fire;
  logic [LVL_W-1:0] lvl_in, first_lvl;

  store_rd_t st_rd;
  store_wr_t st_wr;
  store_q_t  st_q;

  logic                do_add, do_exec, exec_last;
  logic [STAT_W-1:0]   res_status;
  logic [PRIO_W-1:0]   res_prio;
  logic [XPID_W-1:0]   res_pid;
  logic [SLOT_W-1:0]   exec_slot;

  mlpq_store u_store (
    .clk (clk),
    .rst (rst),
    .rd  (st_rd),
    .wr  (st_wr),
    .q   (st_q)
  );

  // control FSM
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_acc) state_next = S_EXEC;
      S_EXEC: if (exec_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    exec_fire = 1'b0;
    unique case (state)
      S_IDLE: req.ready = 1'b1;
      S_EXEC: exec_fire = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  assign req_acc = req.valid && req.ready;

  // input level saturation and lowest non-empty level
  always_comb begin
    if (int'(req.priority_req) >= NUM_LEVELS) lvl_in = LVL_W'(NUM_LEVELS - 1);
    else lvl_in = LVL_W'(req.priority_req);
    first_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (level_nonempty[i]) first_lvl = LVL_W'(i);
    end
  end

  always_comb begin
    st_rd.en        = req_acc;
    st_rd.pl_addr   = req.process_id[PID_BITS-1:0];
    st_rd.fs_addr   = used_count[SLOT_W-1:0];
    st_rd.slot_addr = level_head[first_lvl];
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      func_r  <= req.func;
      lvl_r   <= lvl_in;
      pid_r   <= req.process_id[PID_BITS-1:0];
      first_r <= first_lvl;
      pend_r  <= pend_flags[req.process_id[PID_BITS-1:0]];
    end
  end

  // decode of the held request against the state and the memory read data
  always_comb begin
    do_add     = 1'b0;
    do_exec    = 1'b0;
    res_status = STAT_OK;
    res_prio   = '0;
    res_pid    = '0;
    exec_slot  = level_head[first_r];
    exec_last  = exec_slot == level_tail[first_r];
    case (func_r)
      FUNC_ADD: begin
        if (pend_r) res_status = STAT_DUP;
        else if (used_count >= CNT_W'(CAPACITY)) res_status = STAT_FULL;
        else do_add = 1'b1;
      end
      FUNC_EXEC: begin
        if (level_nonempty == '0) begin
          res_status = STAT_EMPTY;
        end else begin
          do_exec  = 1'b1;
          res_prio = PRIO_W'(first_r);
          res_pid  = XPID_W'(st_q.sp);
        end
      end
      FUNC_SEARCH: begin
        if (pend_r) res_prio = PRIO_W'(st_q.pl);
        else res_status = STAT_NOTFOUND;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_wr         = '0;
    st_wr.pl_addr = pid_r;
    st_wr.pl_data = lvl_r;
    st_wr.sp_addr = st_q.fs;
    st_wr.sp_data = pid_r;
    st_wr.sn_addr = level_tail[lvl_r];
    st_wr.sn_data = st_q.fs;
    st_wr.fs_addr = SLOT_W'(used_count - CNT_W'(1));
    st_wr.fs_data = exec_slot;
    if (exec_fire && do_add) begin
      st_wr.pl_we = 1'b1;
      st_wr.sp_we = 1'b1;
      st_wr.sn_we = level_nonempty[lvl_r];
    end
    if (exec_fire && do_exec) st_wr.fs_we = used_count != '0;
  end

  // level pointers: payload, no reset
  always_ff @(posedge clk) begin
    if (exec_fire && do_add) begin
      if (!level_nonempty[lvl_r]) level_head[lvl_r] <= st_q.fs;
      level_tail[lvl_r] <= st_q.fs;
    end
    if (exec_fire && do_exec && !exec_last) level_head[first_r] <= st_q.sn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pend_flags     <= '0;
      level_nonempty <= '0;
      used_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_fire && do_add) begin
        pend_flags[pid_r]      <= 1'b1;
        level_nonempty[lvl_r]  <= 1'b1;
        used_count             <= used_count + CNT_W'(1);
      end
      if (exec_fire && do_exec) begin
        pend_flags[st_q.sp] <= 1'b0;
        if (exec_last) level_nonempty[first_r] <= 1'b0;
        if (used_count != '0) used_count <= used_count - CNT_W'(1);
      end
      if (exec_fire) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status <= res_status;
      out_prio   <= res_prio;
      out_pid    <= res_pid;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.result_priority = out_prio;
  assign rsp.result_pid      = out_pid;

  `MLPQ_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, used_count <= CNT_W'(CAPACITY), "slot count over capacity")
  `MLPQ_ASSERT_SAME(a_empty_levels, clk, rst, used_count == '0, level_nonempty == '0, "level marked busy with no slot in use")
  `MLPQ_ASSERT_NEXT(a_accept_exec, clk, rst, req_acc, state == S_EXEC, "accepted word not processed next cycle")
  `MLPQ_ASSERT_NEXT(a_fire_valid, clk, rst, exec_fire, out_valid, "processed word has no result word")

endmodule

`default_nettype wire

// ===== bench/multilevel_process_priority_queue_unit_test.sv =====
// Self-checking bench for multilevel_process_priority_queue_unit: directed table, then
// random bursts, checked against a behavioral copy of the level FIFOs.
// Depends on mlpq_pkg, mlpq_req_if, mlpq_rsp_if and the unit itself.
module multilevel_process_priority_queue_unit_test;
  import mlpq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;  // unused code, answers ok
  localparam int RANDOM_ITEMS   = 750;
  localparam int HOLD_AT_WORD   = 400;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int DIRECTED_ROWS  = 21;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PRIO_W-1:0] prio;
    logic [XPID_W-1:0] pid;
  } req_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] prio;
    logic [XPID_W-1:0] pid;
  } rsp_word_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PRIO_W-1:0] prio;
    logic [XPID_W-1:0] pid;
    logic              fixed;
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] rprio;
    logic [XPID_W-1:0] rpid;
  } plan_row_t;

  typedef enum {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIX,
    BURST_NOISE
  } burst_kind_t;

  logic clk;
  logic rst;

  mlpq_req_if req_bus ();
  mlpq_rsp_if rsp_bus ();

  multilevel_process_priority_queue_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // behavioral copy of the queue
  bit                  queued_flag [PID_COUNT];
  logic [LVL_W-1:0]    queued_level [PID_COUNT];
  logic [PID_BITS-1:0] link_pid [CAPACITY];
  logic [SLOT_W-1:0]   link_next [CAPACITY];
  logic [SLOT_W-1:0]   free_stack [CAPACITY];
  logic [SLOT_W-1:0]   head_slot [NUM_LEVELS];
  logic [SLOT_W-1:0]   tail_slot [NUM_LEVELS];
  bit [NUM_LEVELS-1:0] level_busy;
  int                  slots_used;

  rsp_word_t awaited_words [$];
  int        mismatches;
  int        idle_mode;
  int        func_tally [4];
  int        status_tally [8];

  // expected rows: after reset, extremes and error codes are typed in
  plan_row_t directed_plan [DIRECTED_ROWS] = '{
    '{FUNC_EXEC,   3'd0, 8'h00, 1'b1, STAT_EMPTY,    3'd0, 8'h00},
    '{FUNC_SEARCH, 3'd0, 8'hff, 1'b1, STAT_NOTFOUND, 3'd0, 8'h00},
    '{FUNC_NONE,   3'd7, 8'hff, 1'b1, STAT_OK,       3'd0, 8'h00},
    '{FUNC_ADD,    3'd7, 8'hff, 1'b1, STAT_OK,       3'd0, 8'h00},
    '{FUNC_ADD,    3'd0, 8'h00, 1'b1, STAT_OK,       3'd0, 8'h00},
    '{FUNC_ADD,    3'd5, 8'hff, 1'b1, STAT_DUP,      3'd0, 8'h00},
    '{FUNC_SEARCH, 3'd0, 8'hff, 1'b1, STAT_OK,       3'd7, 8'h00},
    '{FUNC_ADD,    3'd3, 8'haa, 1'b0, STAT_OK,       3'd0, 8'h00},
    '{FUNC_ADD,    3'd3, 8'h55, 1'b0, STAT_OK,       3'd0, 8'h00},
    '{FUNC_ADD,    3'd3, 8'h01, 1'b0, STAT_OK,       3'd0, 8'h00},
    '{FUNC_SEARCH, 3'd6, 8'h01, 1'b0, STAT_OK,       3'd0, 8'h00},  // tail of its list
    '{FUNC_EXEC,   3'd7, 8'hff, 1'b0, STAT_OK,       3'd0, 8'h00},
    '{FUNC_EXEC,   3'd0, 8'h00, 1'b0, STAT_OK,       3'd0, 8'h00},
    '{FUNC_SEARCH, 3'd0, 8'haa, 1'b0, STAT_OK,       3'd0, 8'h00},
    '{FUNC_EXEC,   3'd0, 8'h00, 1'b0, STAT_OK,       3'd0, 8'h00},
    '{FUNC_EXEC,   3'd0, 8'h00, 1'b0, STAT_OK,       3'd0, 8'h00},
    '{FUNC_EXEC,   3'd0, 8'h00, 1'b0, STAT_OK,       3'd0, 8'h00},
    '{FUNC_EXEC,   3'd2, 8'h13, 1'b1, STAT_EMPTY,    3'd0, 8'h00},
    '{FUNC_ADD,    3'd7, 8'h80, 1'b0, STAT_OK,       3'd0, 8'h00},
    '{FUNC_SEARCH, 3'd0, 8'h80, 1'b0, STAT_OK,       3'd0, 8'h00},  // only element
    '{FUNC_EXEC,   3'd0, 8'h00, 1'b0, STAT_OK,       3'd0, 8'h00}
  };

  // Applies one request to the queue copy and returns the word it answers.
  function automatic rsp_word_t apply_request(req_word_t w);
    rsp_word_t           r;
    int                  lvl;
    int                  l;
    logic [PID_BITS-1:0] id;
    logic [SLOT_W-1:0]   s;
    r = '0;
    r.status = STAT_OK;
    lvl = int'(w.prio);
    if (lvl >= NUM_LEVELS) lvl = NUM_LEVELS - 1;
    id = w.pid[PID_BITS-1:0];
    case (w.func)
      FUNC_ADD: begin
        if (queued_flag[id]) begin
          r.status = STAT_DUP;
        end else if (slots_used >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          s = free_stack[slots_used];
          slots_used++;
          link_pid[s] = id;
          link_next[s] = '0;
          if (level_busy[lvl]) begin
            link_next[tail_slot[lvl]] = s;
          end else begin
            head_slot[lvl] = s;
            level_busy[lvl] = 1'b1;
          end
          tail_slot[lvl] = s;
          queued_flag[id] = 1'b1;
          queued_level[id] = LVL_W'(lvl);
        end
      end
      FUNC_EXEC: begin
        l = 0;
        while (l < NUM_LEVELS && !level_busy[l]) l++;
        if (l == NUM_LEVELS) begin
          r.status = STAT_EMPTY;
        end else begin
          s = head_slot[l];
          id = link_pid[s];
          if (s == tail_slot[l]) level_busy[l] = 1'b0;
          else head_slot[l] = link_next[s];
          slots_used--;
          free_stack[slots_used] = s;
          queued_flag[id] = 1'b0;
          r.prio = PRIO_W'(l);
          r.pid = XPID_W'(id);
        end
      end
      FUNC_SEARCH: begin
        if (queued_flag[id]) r.prio = PRIO_W'(queued_level[id]);
        else r.status = STAT_NOTFOUND;
      end
      default: ;
    endcase
    return r;
  endfunction

  // percent of cycles one side sits idle in the current phase
  function automatic int idle_share(bit receiver);
    case (idle_mode)
      0: return receiver ? 55 : 26;
      1: return receiver ? 26 : 55;
      default: return 0;
    endcase
  endfunction

  function automatic req_word_t pick_request(burst_kind_t kind, int window_lo);
    req_word_t w;
    int        roll;
    int        wide_pct;
    roll = $urandom_range(99);
    case (kind)
      BURST_FILL:  w.func = roll < 90 ? FUNC_ADD : roll < 95 ? FUNC_SEARCH : FUNC_EXEC;
      BURST_DRAIN: w.func = roll < 75 ? FUNC_EXEC : roll < 88 ? FUNC_SEARCH : FUNC_ADD;
      BURST_MIX: begin
        w.func = roll < 40 ? FUNC_ADD : roll < 72 ? FUNC_EXEC :
                 roll < 95 ? FUNC_SEARCH : FUNC_NONE;
      end
      default: w.func = FUNC_W'($urandom_range(3));
    endcase
    w.prio = PRIO_W'($urandom_range((1 << PRIO_W) - 1));
    // a narrow id window makes duplicates and search hits common
    wide_pct = (kind == BURST_FILL || kind == BURST_NOISE) ? 70 : 35;
    if ($urandom_range(99) < wide_pct) w.pid = XPID_W'($urandom_range(255));
    else w.pid = XPID_W'(window_lo + $urandom_range(95));
    return w;
  endfunction

  // Offers one word and returns at the edge where it is taken.
  task automatic offer(input req_word_t w, output rsp_word_t r);
    while ($urandom_range(99) < idle_share(1'b0)) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.func <= w.func;
    req_bus.priority_req <= w.prio;
    req_bus.process_id <= w.pid;
    do @(posedge clk); while (!req_bus.ready);
    r = apply_request(w);
    func_tally[w.func]++;
    status_tally[r.status]++;
  endtask

  // response side: takes and checks words, stalls at random
  initial begin
    int        words_taken;
    bit        held;
    rsp_word_t want;
    words_taken = 0;
    held = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_bus.valid && rsp_bus.ready) begin
        words_taken++;
        if (awaited_words.size() == 0) begin
          $display("%0t: unexpected word status %0d level %0d pid %0d", $time,
                   rsp_bus.status, rsp_bus.result_priority, rsp_bus.result_pid);
          mismatches++;
        end else begin
          want = awaited_words.pop_front();
          if (rsp_bus.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     rsp_bus.status);
            mismatches++;
          end
          if (rsp_bus.result_priority !== want.prio) begin
            $display("%0t: result_priority expected %0d got %0d", $time, want.prio,
                     rsp_bus.result_priority);
            mismatches++;
          end
          if (rsp_bus.result_pid !== want.pid) begin
            $display("%0t: result_pid expected %0d got %0d", $time, want.pid,
                     rsp_bus.result_pid);
            mismatches++;
          end
        end
      end
      // one long back-pressure stretch so the unit fills and stalls requests
      if (!held && words_taken == HOLD_AT_WORD) begin
        held = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_bus.ready <= ($urandom_range(99) >= idle_share(1'b1));
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no word moved for %0d cycles, %0d still awaited", $time,
             WATCHDOG_LIMIT, awaited_words.size());
    $display("multilevel_process_priority_queue_unit test failed");
    $finish;
  end

  initial begin
    int          i;
    int          sent;
    int          burst_left;
    int          window_lo;
    int          roll;
    burst_kind_t kind;
    req_word_t   w;
    rsp_word_t   r;
    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.func <= FUNC_ADD;
    req_bus.priority_req <= '0;
    req_bus.process_id <= '0;
    mismatches = 0;
    idle_mode = 0;
    slots_used = 0;
    level_busy = '0;
    for (i = 0; i < CAPACITY; i++) free_stack[i] = SLOT_W'(i);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      w = '{directed_plan[i].func, directed_plan[i].prio, directed_plan[i].pid};
      offer(w, r);
      if (directed_plan[i].fixed)
        awaited_words.push_back('{directed_plan[i].status, directed_plan[i].rprio,
                                  directed_plan[i].rpid});
      else
        awaited_words.push_back(r);
    end

    sent = 0;
    burst_left = 0;
    kind = BURST_MIX;
    window_lo = 0;
    while (sent < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        roll = $urandom_range(99);
        kind = roll < 30 ? BURST_FILL : roll < 55 ? BURST_DRAIN :
               roll < 90 ? BURST_MIX : BURST_NOISE;
        burst_left = kind == BURST_FILL ? $urandom_range(70, 130) : $urandom_range(15, 60);
        window_lo = $urandom_range(255);
      end
      idle_mode = sent * 3 / RANDOM_ITEMS;
      w = pick_request(kind, window_lo);
      offer(w, r);
      awaited_words.push_back(r);
      if (w.func != FUNC_NONE) sent++;
      burst_left--;
    end
    req_bus.valid <= 1'b0;

    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d add, %0d execute, %0d search, %0d unknown-op words",
             func_tally[FUNC_ADD], func_tally[FUNC_EXEC], func_tally[FUNC_SEARCH],
             func_tally[FUNC_NONE]);
    $display("answers: %0d duplicate, %0d store full, %0d empty, %0d not found",
             status_tally[STAT_DUP], status_tally[STAT_FULL], status_tally[STAT_EMPTY],
             status_tally[STAT_NOTFOUND]);
    if (mismatches == 0) begin
      $display("multilevel_process_priority_queue_unit test passed");
    end else begin
      $display("multilevel_process_priority_queue_unit test failed");
    end
    $finish;
  end

endmodule
